[hw/rtl/gosd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gosd_pkg
// Shared types, register indexes and reset values of the gyro overflow and
// yaw spin detector.
// ----------------------------------------------------------------------------
package gosd_pkg;

  localparam int RateW    = 20;
  localparam int MagW     = 20;
  localparam int TimeW    = 32;
  localparam int LimitW   = 19;
  localparam int HoldW    = 20;
  localparam int ThrW     = 15;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 20;
  localparam int InDataW  = 96;
  localparam int OutDataW = 8;

  // spin clears below threshold minus this many dps
  localparam logic [ThrW-1:0] SpinHystDps = 15'd100;

  typedef enum logic [CfgIdxW-1:0] {
    REG_OVF_CHECK_EN = 3'd0,
    REG_OVF_AXIS_MASK = 3'd1,
    REG_OVF_TRIGGER_RATE = 3'd2,
    REG_OVF_RESET_RATE = 3'd3,
    REG_OVF_HOLD_US = 3'd4,
    REG_SPIN_EN = 3'd5,
    REG_SPIN_THRESHOLD = 3'd6,
    REG_SPIN_HOLD_US = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic              overflow_check_enable;
    logic [2:0]        overflow_axis_mask;
    logic [LimitW-1:0] overflow_trigger_rate;
    logic [LimitW-1:0] overflow_reset_rate;
    logic [HoldW-1:0]  overflow_hold_us;
    logic              spin_enable;
    logic [ThrW-1:0]   spin_threshold_dps;
    logic [HoldW-1:0]  spin_hold_us;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    overflow_check_enable: 1'b1,
    overflow_axis_mask:    3'd7,
    overflow_trigger_rate: 19'd31230,
    overflow_reset_rate:   19'd29629,
    overflow_hold_us:      20'd50000,
    spin_enable:           1'b1,
    spin_threshold_dps:    15'd1950,
    spin_hold_us:          20'd20000
  };

  // rate_x sits in the lowest bits
  typedef struct packed {
    logic [TimeW-1:0]        time_us;
    logic signed [RateW-1:0] rate_z;
    logic signed [RateW-1:0] rate_y;
    logic signed [RateW-1:0] rate_x;
  } item_t;

  typedef struct packed {
    logic imu_update_enable;
    logic spin_flag;
    logic overflow_flag;
  } result_t;

  // magnitude of a signed rate; the most negative value maps to 2^19
  function automatic logic [MagW-1:0] rate_mag(input logic signed [RateW-1:0] v);
    logic [MagW-1:0] neg;
    neg = MagW'(0) - MagW'(v);
    return v[RateW-1] ? neg : MagW'(v);
  endfunction

  // signed wrap difference now - mark strictly greater than hold
  function automatic logic hold_expired(input logic [TimeW-1:0] now,
                                        input logic [TimeW-1:0] mark,
                                        input logic [HoldW-1:0] hold);
    logic [TimeW-1:0] d;
    d = now - mark;
    return !d[TimeW-1] && (d[TimeW-2:0] > (TimeW-1)'(hold));
  endfunction

endpackage
`default_nettype wire

[hw/rtl/gosd_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gosd_cfg
// Configuration register file, written through the index/data channel.
// ----------------------------------------------------------------------------
module gosd_cfg
  import gosd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_valid,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  output cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CfgReset;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_OVF_CHECK_EN:     cfg.overflow_check_enable <= cfg_data[0];
        REG_OVF_AXIS_MASK:    cfg.overflow_axis_mask    <= cfg_data[2:0];
        REG_OVF_TRIGGER_RATE: cfg.overflow_trigger_rate <= cfg_data[LimitW-1:0];
        REG_OVF_RESET_RATE:   cfg.overflow_reset_rate   <= cfg_data[LimitW-1:0];
        REG_OVF_HOLD_US:      cfg.overflow_hold_us      <= cfg_data[HoldW-1:0];
        REG_SPIN_EN:          cfg.spin_enable           <= cfg_data[0];
        REG_SPIN_THRESHOLD:   cfg.spin_threshold_dps    <= cfg_data[ThrW-1:0];
        REG_SPIN_HOLD_US:     cfg.spin_hold_us          <= cfg_data[HoldW-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[hw/rtl/gosd_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gosd_core
// Overflow and spin latches with their mark times; computes the flags for
// the registered item and commits the new state when the item advances.
// ----------------------------------------------------------------------------
module gosd_core
  import gosd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic advance,
  input  item_t     item,
  input  cfg_t      cfg,
  output result_t   result
);

  logic             overflow_latched;
  logic             overflow_latched_next;
  logic [TimeW-1:0] overflow_mark_time;
  logic [TimeW-1:0] overflow_mark_time_next;
  logic             spin_latched;
  logic             spin_latched_next;
  logic [TimeW-1:0] spin_mark_time;
  logic [TimeW-1:0] spin_mark_time_next;

  logic [MagW-1:0]  mag_x;
  logic [MagW-1:0]  mag_y;
  logic [MagW-1:0]  mag_z;
  logic [2:0]       hits;
  logic             all_low;
  logic             ovf_set;
  logic             spin_mid;
  logic [ThrW-1:0]  spin_low_dps;
  logic             spin_low;

  always_comb begin
    mag_x = rate_mag(item.rate_x);
    mag_y = rate_mag(item.rate_y);
    mag_z = rate_mag(item.rate_z);

    hits[0] = mag_x > MagW'(cfg.overflow_trigger_rate);
    hits[1] = mag_y > MagW'(cfg.overflow_trigger_rate);
    hits[2] = mag_z > MagW'(cfg.overflow_trigger_rate);
    all_low = (mag_x < MagW'(cfg.overflow_reset_rate)) &&
              (mag_y < MagW'(cfg.overflow_reset_rate)) &&
              (mag_z < MagW'(cfg.overflow_reset_rate));

    overflow_latched_next   = overflow_latched;
    overflow_mark_time_next = overflow_mark_time;
    ovf_set                 = 1'b0;
    if (cfg.overflow_check_enable) begin
      if (overflow_latched) begin
        if (all_low) begin
          if (hold_expired(item.time_us, overflow_mark_time, cfg.overflow_hold_us)) begin
            overflow_latched_next = 1'b0;
          end
        end else begin
          overflow_mark_time_next = item.time_us;
        end
      end else if ((hits & cfg.overflow_axis_mask) != 3'd0) begin
        ovf_set                 = 1'b1;
        overflow_latched_next   = 1'b1;
        overflow_mark_time_next = item.time_us;
      end
    end

    // a fresh overflow drops spin even with spin detection off
    spin_mid = spin_latched && !ovf_set;

    // below threshold minus hysteresis; never true under 100 dps
    spin_low_dps = cfg.spin_threshold_dps - SpinHystDps;
    spin_low     = (cfg.spin_threshold_dps >= SpinHystDps) &&
                   (mag_z < {1'b0, spin_low_dps, 4'd0});

    spin_latched_next   = spin_mid;
    spin_mark_time_next = spin_mark_time;
    if (cfg.spin_enable) begin
      if (overflow_latched_next) begin
        spin_latched_next = 1'b0;
      end else if (spin_mid) begin
        if (spin_low) begin
          if (hold_expired(item.time_us, spin_mark_time, cfg.spin_hold_us)) begin
            spin_latched_next = 1'b0;
          end
        end else begin
          spin_mark_time_next = item.time_us;
        end
      end else if (mag_z[MagW-1:4] > (MagW-4)'(cfg.spin_threshold_dps)) begin
        spin_latched_next   = 1'b1;
        spin_mark_time_next = item.time_us;
      end
    end

    result.overflow_flag     = overflow_latched_next;
    result.spin_flag         = spin_latched_next;
    result.imu_update_enable = !overflow_latched_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_latched   <= 1'b0;
      overflow_mark_time <= '0;
      spin_latched       <= 1'b0;
      spin_mark_time     <= '0;
    end else if (advance) begin
      overflow_latched   <= overflow_latched_next;
      overflow_mark_time <= overflow_mark_time_next;
      spin_latched       <= spin_latched_next;
      spin_mark_time     <= spin_mark_time_next;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/gyro_overflow_spin_detector.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gyro_overflow_spin_detector
// Latches gyro overflow and yaw spin from a stream of gyro rate samples.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one sample per transfer: three signed rates in 1/16 dps and
//   a wrapping microsecond timestamp. m_* returns one result per sample:
//   overflow flag, spin flag and imu update enable.
//   cfg_* writes one register per transfer (index, data); cfg_ready is
//   always high. Write registers only while no sample is in flight.
//   A sample is held in the input register, then the flag logic runs against
//   the latch state and loads the result register, updating the state in
//   that edge. Throughput is one sample per cycle while m_tready stays high.
//   When m_tready is low the result register holds its data; one more sample
//   is taken into the input register and then s_tready drops until the
//   result is taken.
//   Synchronous reset clears both latches and mark times, empties both
//   registers and restores the register defaults.
// ----------------------------------------------------------------------------
module gyro_overflow_spin_detector
  import gosd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // [19:0] rate_x, [39:20] rate_y, [59:40] rate_z, [91:60] time_us, rest zero
  input  wire logic [InDataW-1:0]  s_tdata,
  input  wire logic                s_tvalid,
  output      logic                s_tready,
  // [0] overflow_flag, [1] spin_flag, [2] imu_update_enable, rest zero
  output      logic [OutDataW-1:0] m_tdata,
  output      logic                m_tvalid,
  input  wire logic                m_tready,
  input  wire logic                cfg_valid,
  output      logic                cfg_ready,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  cfg_t    cfg;
  item_t   item;
  logic    item_valid;
  logic    advance;
  result_t result;
  result_t result_reg;

  assign cfg_ready = 1'b1;

  gosd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // item moves on when the result register is free or being emptied
  assign advance  = item_valid && (!m_tvalid || m_tready);
  assign s_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item <= s_tdata[$bits(item_t)-1:0];
    end
  end

  gosd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_reg <= result;
    end
  end

  assign m_tdata = {(OutDataW - $bits(result_t))'(0), result_reg};

endmodule
`default_nettype wire
